>>> rtl/path_component_parser_unit_defines.svh
// Assertion macros shared by the path component parser files.
`ifndef PATH_COMPONENT_PARSER_UNIT_DEFINES_SVH
`define PATH_COMPONENT_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define PCP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("path component parser check failed");

// next-cycle implication
`define PCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("path component parser check failed");

`endif

>>> rtl/pcp_pkg.sv
// Constants, codes and shared structs for the path component parser.
package pcp_pkg;

   localparam int MAX_NAME_CHARS = 16;
   localparam int MAX_COMPONENTS = 16;
   localparam int MAX_PATH_CHARS = 512;

   // fixed field widths
   localparam int CH_W     = 8;
   localparam int IDX_W    = 4;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int DEPTH_W  = 5;
   localparam int LEN_W    = 5;

   // derived storage sizes and widths
   localparam int SLOTS       = MAX_COMPONENTS + 1;
   localparam int STORE_DEPTH = SLOTS * MAX_NAME_CHARS;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CLEN_W      = $clog2(MAX_NAME_CHARS + 1);
   localparam int DEPTH_CNT_W = $clog2(SLOTS + 1);
   localparam int PLEN_W      = $clog2(MAX_PATH_CHARS + 2);

   localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_PATH_LONG = 2'd1,
      ST_NAME_LONG = 2'd2,
      ST_TOO_DEEP  = 2'd3
   } status_type;

   typedef enum logic {
      MODE_PATH = 1'b0,
      MODE_READ = 1'b1
   } mode_type;

   typedef enum logic {
      KIND_SUMMARY = 1'b0,
      KIND_READ    = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      DOT_NONE = 2'd0,
      DOT_ONE  = 2'd1,
      DOT_TWO  = 2'd2
   } dot_type;

   typedef struct packed {
      status_type         status;
      logic               absolute;
      logic               is_dir;
      logic [DEPTH_W-1:0] depth;
   } sum_type;

   typedef struct packed {
      kind_type         kind;
      sum_type          sum;
      logic             comp_ok;
      logic [POS_W-1:0] char_pos;
   } issue_type;

   typedef struct packed {
      logic                name_we;
      logic [STORE_AW-1:0] name_addr;
      logic [CH_W-1:0]     name_data;
      logic                len_we;
      logic [SLOT_W-1:0]   len_addr;
      logic [CLEN_W-1:0]   len_data;
   } store_wr_type;

endpackage

>>> rtl/path_component_parser_unit.sv
// Top level of the path component parser.
//
// Takes one word per cycle, back to back, while req_stall is low. A path word
// (mode 0) carries one path character; the path ends on a zero character or on
// last, and that word yields one summary (status, absolute, directory flag,
// depth). A read word (mode 1) returns one stored name character and that
// name's length. Words that only carry a path character yield nothing. Every
// result waits in a first register beside the memory read data, then in the
// output register: names and name lengths sit in two memories with one write
// port and a registered read port each, and the output has its own register.
// Characters are written at the edge that takes them and a read word can come
// no earlier than the next edge, so reads always see the latest names without
// forwarding. Per-path counters live in flip-flops and update on every path
// word taken. req_stall rises only while both result registers are full and
// rsp_stall is high. The memories need no clearing after reset: entries beyond
// the current depth or name length are never returned.
`include "path_component_parser_unit_defines.svh"

module path_component_parser_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_mode,
   input  logic [pcp_pkg::CH_W-1:0]     req_ch,
   input  logic                         req_last,
   input  logic [pcp_pkg::IDX_W-1:0]    req_comp_index,
   input  logic [pcp_pkg::POS_W-1:0]    req_char_pos,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_kind,
   output logic [pcp_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_absolute,
   output logic                         rsp_is_dir,
   output logic [pcp_pkg::DEPTH_W-1:0]  rsp_path_depth,
   output logic [pcp_pkg::CH_W-1:0]     rsp_read_char,
   output logic [pcp_pkg::LEN_W-1:0]    rsp_read_len
);

   logic                            accept;
   logic                            path_step;
   logic                            read_step;
   logic                            can_take;
   logic                            tok_done;
   logic [pcp_pkg::DEPTH_CNT_W-1:0] tok_depth;
   pcp_pkg::store_wr_type           tok_wr;
   pcp_pkg::sum_type                tok_sum;
   logic [pcp_pkg::CH_W-1:0]        mem_char;
   logic [pcp_pkg::CLEN_W-1:0]      mem_len;
   logic                            issue_valid;
   pcp_pkg::issue_type              issue;

   assign req_stall = !can_take;
   assign accept    = req_valid && can_take;
   assign path_step = accept && (req_mode == pcp_pkg::MODE_PATH);
   assign read_step = accept && (req_mode == pcp_pkg::MODE_READ);

   pcp_tokenizer u_tokenizer (
      .clock (clock),
      .reset (reset),
      .step  (path_step),
      .ch    (req_ch),
      .last  (req_last),
      .wr    (tok_wr),
      .sum   (tok_sum),
      .done  (tok_done),
      .depth (tok_depth)
   );

   pcp_store u_store (
      .clock   (clock),
      .wr      (tok_wr),
      .rd_en   (read_step),
      .rd_comp (req_comp_index),
      .rd_pos  (req_char_pos),
      .rd_char (mem_char),
      .rd_len  (mem_len)
   );

   assign issue_valid    = read_step || (path_step && tok_done);
   assign issue.kind     = read_step ? pcp_pkg::KIND_READ : pcp_pkg::KIND_SUMMARY;
   assign issue.sum      = tok_sum;
   assign issue.comp_ok  = (32'(req_comp_index) < 32'(tok_depth));
   assign issue.char_pos = req_char_pos;

   pcp_resp u_resp (
      .clock          (clock),
      .reset          (reset),
      .issue_valid    (issue_valid),
      .issue          (issue),
      .mem_char       (mem_char),
      .mem_len        (mem_len),
      .can_take       (can_take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_status     (rsp_status),
      .rsp_absolute   (rsp_absolute),
      .rsp_is_dir     (rsp_is_dir),
      .rsp_path_depth (rsp_path_depth),
      .rsp_read_char  (rsp_read_char),
      .rsp_read_len   (rsp_read_len)
   );

   // input backs up only behind a full, stalled output
   `PCP_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   // failed path is never reported as a directory
   `PCP_ASSERT_IMPLY(a_err_not_dir, clock, reset,
      rsp_valid && rsp_kind == pcp_pkg::KIND_SUMMARY && rsp_status != pcp_pkg::ST_OK,
      !rsp_is_dir)
   // read word: no character without a name length behind it
   `PCP_ASSERT_IMPLY(a_read_gated, clock, reset,
      rsp_valid && rsp_kind == pcp_pkg::KIND_READ && rsp_read_len == '0,
      rsp_read_char == '0)
   // one word into an empty output cannot back up the input
   `PCP_ASSERT_NEXT(a_no_early_stall, clock, reset,
      issue_valid && !rsp_valid && !u_resp.a_valid_ff, !req_stall)

endmodule

>>> rtl/pcp_store.sv
// Name character memory and name length memory with registered read port.
module pcp_store (
   input  logic                       clock,
   input  pcp_pkg::store_wr_type      wr,
   input  logic                       rd_en,
   input  logic [pcp_pkg::IDX_W-1:0]  rd_comp,
   input  logic [pcp_pkg::POS_W-1:0]  rd_pos,
   output logic [pcp_pkg::CH_W-1:0]   rd_char,
   output logic [pcp_pkg::CLEN_W-1:0] rd_len
);

   logic [pcp_pkg::CH_W-1:0]     name_mem [pcp_pkg::STORE_DEPTH];
   logic [pcp_pkg::CLEN_W-1:0]   len_mem  [pcp_pkg::SLOTS];
   logic [pcp_pkg::CH_W-1:0]     rd_char_ff;
   logic [pcp_pkg::CLEN_W-1:0]   rd_len_ff;
   logic [pcp_pkg::STORE_AW-1:0] rd_addr;
   logic [pcp_pkg::SLOT_W-1:0]   rd_slot;

   assign rd_addr = pcp_pkg::STORE_AW'(rd_comp) * pcp_pkg::STORE_AW'(pcp_pkg::MAX_NAME_CHARS)
                    + pcp_pkg::STORE_AW'(rd_pos);
   assign rd_slot = pcp_pkg::SLOT_W'(rd_comp);

   always_ff @(posedge clock) begin
      if (wr.name_we) begin
         name_mem[wr.name_addr] <= wr.name_data;
      end
      if (rd_en) begin
         rd_char_ff <= name_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.len_we) begin
         len_mem[wr.len_addr] <= wr.len_data;
      end
      if (rd_en) begin
         rd_len_ff <= len_mem[rd_slot];
      end
   end

   assign rd_char = rd_char_ff;
   assign rd_len  = rd_len_ff;

endmodule

>>> rtl/pcp_tokenizer.sv
// Per-path scanner state: splits path words into names and builds the summary.
module pcp_tokenizer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [pcp_pkg::CH_W-1:0]        ch,
   input  logic                            last,
   output pcp_pkg::store_wr_type           wr,
   output pcp_pkg::sum_type                sum,
   output logic                            done,
   output logic [pcp_pkg::DEPTH_CNT_W-1:0] depth
);

   logic [pcp_pkg::DEPTH_CNT_W-1:0] depth_ff, depth_in;
   logic [pcp_pkg::PLEN_W-1:0]      plen_ff, plen_in;
   logic [pcp_pkg::CLEN_W-1:0]      comp_ff, comp_in;
   logic                            abs_ff, abs_in;
   logic                            lead_ff, lead_in;
   pcp_pkg::dot_type                dot_ff, dot_in;
   logic                            slash_ff, slash_in;
   pcp_pkg::status_type             err_ff, err_in;
   logic                            dotdot_ff, dotdot_in;

   always_comb begin
      logic                start;
      logic                has_ch;
      logic                is_slash;
      logic                fin;
      logic                keep;
      pcp_pkg::status_type st;

      start    = (plen_ff == '0);
      has_ch   = (ch != '0);
      is_slash = (ch == pcp_pkg::CH_SLASH);

      // a new path begins with the first path word after a summary
      depth_in  = start ? '0 : depth_ff;
      comp_in   = start ? '0 : comp_ff;
      abs_in    = start ? 1'b0 : abs_ff;
      lead_in   = start ? 1'b1 : lead_ff;
      dot_in    = start ? pcp_pkg::DOT_NONE : dot_ff;
      slash_in  = start ? 1'b0 : slash_ff;
      err_in    = start ? pcp_pkg::ST_OK : err_ff;
      dotdot_in = start ? 1'b0 : dotdot_ff;
      plen_in   = plen_ff;
      wr        = '0;

      if (has_ch) begin
         if (start) begin
            abs_in  = is_slash;
            lead_in = is_slash;
         end
         if (plen_in <= pcp_pkg::PLEN_W'(pcp_pkg::MAX_PATH_CHARS)) begin
            plen_in = plen_in + 1'b1;
         end
         if (is_slash) begin
            slash_in = 1'b1;
         end else begin
            slash_in = 1'b0;
            if (err_in == pcp_pkg::ST_OK) begin
               if (comp_in >= pcp_pkg::CLEN_W'(pcp_pkg::MAX_NAME_CHARS)) begin
                  err_in = pcp_pkg::ST_NAME_LONG;
               end else begin
                  wr.name_we   = 1'b1;
                  wr.name_addr = pcp_pkg::STORE_AW'(depth_in)
                                 * pcp_pkg::STORE_AW'(pcp_pkg::MAX_NAME_CHARS)
                                 + pcp_pkg::STORE_AW'(comp_in);
                  wr.name_data = ch;
                  if (comp_in == '0) begin
                     dot_in = (ch == pcp_pkg::CH_DOT) ? pcp_pkg::DOT_ONE : pcp_pkg::DOT_NONE;
                  end else if (dot_in == pcp_pkg::DOT_ONE && ch == pcp_pkg::CH_DOT) begin
                     dot_in = pcp_pkg::DOT_TWO;
                  end else begin
                     dot_in = pcp_pkg::DOT_NONE;
                  end
                  comp_in = comp_in + 1'b1;
               end
            end
         end
      end

      done = !has_ch || last;
      // a slash and the path end close the current name the same way
      fin  = (has_ch && is_slash) || done;
      keep = fin && (comp_in != '0) && (err_in == pcp_pkg::ST_OK)
             && !(dot_in == pcp_pkg::DOT_ONE
                  || (dot_in == pcp_pkg::DOT_TWO && abs_in && lead_in));

      if (keep) begin
         wr.len_we   = (depth_in < pcp_pkg::DEPTH_CNT_W'(pcp_pkg::SLOTS));
         wr.len_addr = pcp_pkg::SLOT_W'(depth_in);
         wr.len_data = comp_in;
         dotdot_in   = (dot_in == pcp_pkg::DOT_TWO);
         depth_in    = depth_in + 1'b1;
         lead_in     = 1'b0;
         if (depth_in > pcp_pkg::DEPTH_CNT_W'(pcp_pkg::MAX_COMPONENTS)) begin
            err_in = pcp_pkg::ST_TOO_DEEP;
         end
      end
      if (fin) begin
         comp_in = '0;
         dot_in  = pcp_pkg::DOT_NONE;
      end

      st = (plen_in > pcp_pkg::PLEN_W'(pcp_pkg::MAX_PATH_CHARS)) ? pcp_pkg::ST_PATH_LONG : err_in;
      sum.status   = st;
      sum.absolute = abs_in;
      sum.is_dir   = (st == pcp_pkg::ST_OK) && (slash_in || depth_in == '0 || dotdot_in);
      sum.depth    = (depth_in > pcp_pkg::DEPTH_CNT_W'(pcp_pkg::MAX_COMPONENTS))
                     ? pcp_pkg::DEPTH_W'(pcp_pkg::MAX_COMPONENTS)
                     : pcp_pkg::DEPTH_W'(depth_in);

      if (done) begin
         plen_in = '0;
      end

      wr.name_we = wr.name_we && step;
      wr.len_we  = wr.len_we && step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         plen_ff   <= '0;
         comp_ff   <= '0;
         abs_ff    <= 1'b0;
         lead_ff   <= 1'b1;
         dot_ff    <= pcp_pkg::DOT_NONE;
         slash_ff  <= 1'b0;
         err_ff    <= pcp_pkg::ST_OK;
         dotdot_ff <= 1'b0;
      end else if (step) begin
         depth_ff  <= depth_in;
         plen_ff   <= plen_in;
         comp_ff   <= comp_in;
         abs_ff    <= abs_in;
         lead_ff   <= lead_in;
         dot_ff    <= dot_in;
         slash_ff  <= slash_in;
         err_ff    <= err_in;
         dotdot_ff <= dotdot_in;
      end
   end

   assign depth = depth_ff;

endmodule

>>> rtl/pcp_resp.sv
// Two result registers: memory data stage and output stage with flow control.
module pcp_resp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            issue_valid,
   input  pcp_pkg::issue_type              issue,
   input  logic [pcp_pkg::CH_W-1:0]        mem_char,
   input  logic [pcp_pkg::CLEN_W-1:0]      mem_len,
   output logic                            can_take,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_kind,
   output logic [pcp_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_absolute,
   output logic                            rsp_is_dir,
   output logic [pcp_pkg::DEPTH_W-1:0]     rsp_path_depth,
   output logic [pcp_pkg::CH_W-1:0]        rsp_read_char,
   output logic [pcp_pkg::LEN_W-1:0]       rsp_read_len
);

   logic                          a_valid_ff;
   pcp_pkg::issue_type            a_ff;
   logic                          b_valid_ff;
   pcp_pkg::kind_type             kind_ff, kind_in;
   pcp_pkg::sum_type              sum_ff, sum_in;
   logic [pcp_pkg::CH_W-1:0]      char_ff, char_in;
   logic [pcp_pkg::LEN_W-1:0]     len_ff, len_in;
   logic                          b_free;
   logic                          a_move;

   assign b_free   = !b_valid_ff || !rsp_stall;
   assign a_move   = a_valid_ff && b_free;
   assign can_take = !a_valid_ff || b_free;

   // memory data lines up with the A stage: read issued when the word entered A
   always_comb begin
      logic char_ok;
      kind_in = a_ff.kind;
      sum_in  = '0;
      char_in = '0;
      len_in  = '0;
      char_ok = a_ff.comp_ok && (32'(a_ff.char_pos) < 32'(mem_len));
      if (a_ff.kind == pcp_pkg::KIND_READ) begin
         len_in  = a_ff.comp_ok ? pcp_pkg::LEN_W'(mem_len) : '0;
         char_in = char_ok ? mem_char : '0;
      end else begin
         sum_in = a_ff.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (can_take) begin
            a_valid_ff <= issue_valid;
         end
         if (b_free) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue_valid) begin
         a_ff <= issue;
      end
      if (a_move) begin
         kind_ff <= kind_in;
         sum_ff  <= sum_in;
         char_ff <= char_in;
         len_ff  <= len_in;
      end
   end

   assign rsp_valid      = b_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_status     = sum_ff.status;
   assign rsp_absolute   = sum_ff.absolute;
   assign rsp_is_dir     = sum_ff.is_dir;
   assign rsp_path_depth = sum_ff.depth;
   assign rsp_read_char  = char_ff;
   assign rsp_read_len   = len_ff;

endmodule
